// ===== rtl/u8v_pkg.sv =====
// Shared types, constants and limits for the UTF-8 string validator.
// Used by the interfaces, the decode stage, the response register and the top level.
package u8v_pkg;

   // Longest accepted string, in bytes
   localparam int MaxBytes = 64;

   // Count register wide enough for MaxBytes, never narrower than the reported length
   localparam int LenWidth = 7;
   localparam int CntNeed  = $clog2(MaxBytes + 1);
   localparam int CntWidth = (CntNeed > LenWidth) ? CntNeed : LenWidth;

   localparam int ByteWidth = 8;
   localparam int AccWidth  = 21;

   // Lead byte ranges
   localparam logic [ByteWidth-1:0] LeadTwoLo   = 8'hC2;
   localparam logic [ByteWidth-1:0] LeadTwoHi   = 8'hDF;
   localparam logic [ByteWidth-1:0] LeadThreeLo = 8'hE0;
   localparam logic [ByteWidth-1:0] LeadThreeHi = 8'hEF;
   localparam logic [ByteWidth-1:0] LeadFourLo  = 8'hF0;
   localparam logic [ByteWidth-1:0] LeadFourHi  = 8'hF4;
   localparam logic [ByteWidth-1:0] EndOfText   = 8'h00;

   // Code point limits
   localparam logic [AccWidth-1:0] FloorTwo     = 21'h00080;
   localparam logic [AccWidth-1:0] FloorThree   = 21'h00800;
   localparam logic [AccWidth-1:0] FloorFour    = 21'h10000;
   localparam logic [AccWidth-1:0] CodeMax      = 21'h10FFFF;
   localparam logic [AccWidth-1:0] SurrogateLo  = 21'h0D800;
   localparam logic [AccWidth-1:0] SurrogateHi  = 21'h0DFFF;

   localparam logic [1:0] ContTag = 2'b10;

   // Length class of the sequence being decoded
   typedef enum logic [1:0] {
      CLS_NONE,
      CLS_TWO,
      CLS_THREE,
      CLS_FOUR
   } u8v_class_type;

   // Running decode state
   typedef struct packed {
      logic                err;
      logic [CntWidth-1:0] cnt;
      logic [1:0]          left;
      logic [AccWidth-1:0] acc;
      u8v_class_type       cls;
   } u8v_state_type;

   // Result of one terminated string
   typedef struct packed {
      logic                ok;
      logic [LenWidth-1:0] len;
   } u8v_result_type;

endpackage

// ===== rtl/u8v_ifs.sv =====
// Valid/ready channel interfaces for string bytes and string results.
// Depends on u8v_pkg for field widths.
interface u8v_req_if;
   logic                          valid;
   logic                          ready;
   logic [u8v_pkg::ByteWidth-1:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

interface u8v_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         string_ok;
   logic [u8v_pkg::LenWidth-1:0] byte_length;

   modport source (output valid, output string_ok, output byte_length, input ready);
   modport sink   (input valid, input string_ok, input byte_length, output ready);
endinterface

// ===== rtl/u8v_decode.sv =====
// Next-state logic of the validator: one byte against the running decode state.
// Depends on u8v_pkg for the state and result types and the byte ranges.
module u8v_decode (
   input  logic [u8v_pkg::ByteWidth-1:0] text_byte,
   input  u8v_pkg::u8v_state_type        st,
   output u8v_pkg::u8v_state_type        st_nxt,
   output logic                          term,
   output u8v_pkg::u8v_result_type       res
);

   logic [u8v_pkg::AccWidth-1:0] acc_sh;
   logic [u8v_pkg::AccWidth-1:0] floor_val;
   logic                         range_bad;

   // Shift in six payload bits of a continuation
   assign acc_sh = {st.acc[u8v_pkg::AccWidth-7:0], text_byte[5:0]};

   // Smallest code point allowed for the sequence length
   always_comb begin
      case (st.cls)
         u8v_pkg::CLS_TWO:   floor_val = u8v_pkg::FloorTwo;
         u8v_pkg::CLS_THREE: floor_val = u8v_pkg::FloorThree;
         default:            floor_val = u8v_pkg::FloorFour;
      endcase
   end

   // Overlong, beyond the last plane, or surrogate
   assign range_bad = (acc_sh < floor_val) || (acc_sh > u8v_pkg::CodeMax) ||
                      ((acc_sh >= u8v_pkg::SurrogateLo) && (acc_sh <= u8v_pkg::SurrogateHi));

   // Terminator result
   assign term    = (text_byte == u8v_pkg::EndOfText);
   assign res.ok  = !st.err && (st.cnt != '0) && (st.left == 2'd0);
   assign res.len = st.cnt[u8v_pkg::LenWidth-1:0];

   // Update count, sequence tracking and error flag
   always_comb begin
      st_nxt = st;
      if (term) begin
         st_nxt = '0;
      end else begin
         if (st.cnt >= u8v_pkg::CntWidth'(u8v_pkg::MaxBytes)) begin
            st_nxt.err = 1'b1;
         end else begin
            st_nxt.cnt = st.cnt + 1'b1;
         end

         if (st.left != 2'd0) begin
            if (text_byte[7:6] != u8v_pkg::ContTag) begin
               // Abandon the sequence, do not reread the byte as a lead
               st_nxt.err  = 1'b1;
               st_nxt.left = 2'd0;
               st_nxt.acc  = '0;
               st_nxt.cls  = u8v_pkg::CLS_NONE;
            end else begin
               st_nxt.left = st.left - 2'd1;
               if (st.left == 2'd1) begin
                  if (range_bad) begin
                     st_nxt.err = 1'b1;
                  end
                  st_nxt.acc = '0;
                  st_nxt.cls = u8v_pkg::CLS_NONE;
               end else begin
                  st_nxt.acc = acc_sh;
               end
            end
         end else if (!text_byte[7]) begin
            // Plain ASCII: nothing to track
         end else if ((text_byte >= u8v_pkg::LeadTwoLo) &&
                      (text_byte <= u8v_pkg::LeadTwoHi)) begin
            st_nxt.left = 2'd1;
            st_nxt.acc  = u8v_pkg::AccWidth'(text_byte[4:0]);
            st_nxt.cls  = u8v_pkg::CLS_TWO;
         end else if ((text_byte >= u8v_pkg::LeadThreeLo) &&
                      (text_byte <= u8v_pkg::LeadThreeHi)) begin
            st_nxt.left = 2'd2;
            st_nxt.acc  = u8v_pkg::AccWidth'(text_byte[3:0]);
            st_nxt.cls  = u8v_pkg::CLS_THREE;
         end else if ((text_byte >= u8v_pkg::LeadFourLo) &&
                      (text_byte <= u8v_pkg::LeadFourHi)) begin
            st_nxt.left = 2'd3;
            st_nxt.acc  = u8v_pkg::AccWidth'(text_byte[2:0]);
            st_nxt.cls  = u8v_pkg::CLS_FOUR;
         end else begin
            st_nxt.err = 1'b1;
         end
      end
   end

endmodule

// ===== rtl/u8v_rsp_reg.sv =====
// Output register of the validator: holds one result beat until it is taken.
// Depends on u8v_pkg and the u8v_rsp_if interface.
module u8v_rsp_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  u8v_pkg::u8v_result_type res,
   output logic                    free,
   u8v_rsp_if.source               rsp
);

   logic                         valid_ff;
   logic                         valid_in;
   logic                         ok_ff;
   logic [u8v_pkg::LenWidth-1:0] len_ff;

   // Slot can take a new beat when empty or draining this cycle
   assign free = !valid_ff || rsp.ready;

   // Set on load, drop when taken
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on load
   always_ff @(posedge clock) begin
      if (load) begin
         ok_ff  <= res.ok;
         len_ff <= res.len;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.string_ok   = ok_ff;
   assign rsp.byte_length = len_ff;

endmodule

// ===== rtl/utf8_string_validator_unit.sv =====
// UTF-8 string validator: one result beat per terminator.
// A terminator's result is registered in the result slot as the byte leaves the input stage.
// Throughput: one byte per cycle while no terminator waits on a full result slot.
// Reset (synchronous, active high) clears the input stage, decode state and result slot.
// Depends on u8v_pkg, u8v_ifs, u8v_decode and u8v_rsp_reg.
module utf8_string_validator_unit (
   input  logic    clock,
   input  logic    reset,
   u8v_req_if.sink   req,
   u8v_rsp_if.source rsp
);

   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic [u8v_pkg::ByteWidth-1:0] s1_byte_ff;
   u8v_pkg::u8v_state_type        st_ff;
   u8v_pkg::u8v_state_type        st_in;
   logic                          term;
   u8v_pkg::u8v_result_type       res;
   logic                          rsp_free;
   logic                          s1_adv;
   logic                          req_take;

   // Decode the held byte against the running state
   u8v_decode u_decode (
      .text_byte (s1_byte_ff),
      .st        (st_ff),
      .st_nxt    (st_in),
      .term      (term),
      .res       (res)
   );

   // Result slot
   u8v_rsp_reg u_rsp_reg (
      .clock (clock),
      .reset (reset),
      .load  (s1_adv && term),
      .res   (res),
      .free  (rsp_free),
      .rsp   (rsp)
   );

   // Advance the input stage unless a terminator waits on a full result slot
   assign s1_adv    = s1_valid_ff && (!term || rsp_free);
   assign req.ready = !s1_valid_ff || s1_adv;
   assign req_take  = req.valid && req.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Hold the input byte
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req.text_byte;
      end
   end

   // Commit the decode state as each byte leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (s1_adv) begin
         st_ff <= st_in;
      end
   end

   // A terminator leaves the state cleared
   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && term) |=> (st_ff.cnt == '0 && st_ff.left == 2'd0 && !st_ff.err))
      else $error("decode state not cleared after terminator");

   // The count never passes the length limit
   a_cnt_limit: assert property (@(posedge clock) disable iff (reset)
      st_ff.cnt <= u8v_pkg::CntWidth'(u8v_pkg::MaxBytes))
      else $error("byte count beyond limit");

   // No open sequence means no partial code point
   a_idle_acc: assert property (@(posedge clock) disable iff (reset)
      (st_ff.left == 2'd0) |-> (st_ff.acc == '0 && st_ff.cls == u8v_pkg::CLS_NONE))
      else $error("stale code point with no open sequence");

   // A result is written only into a free slot
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && term) |-> (!rsp.valid || rsp.ready))
      else $error("result overwrote a pending beat");

endmodule
